// ----- rtl/dhfk_pkg.sv -----
package dhfk_pkg;

  localparam int MAX_LINKS    = 8;
  localparam int ANGLE_WIDTH  = 16;
  localparam int LENGTH_WIDTH = 32;

  localparam int CNT_W  = 4;
  localparam int TW     = 32;
  localparam int OPW    = ((LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32) + 1;
  localparam int PW     = 2 * OPW;
  localparam int ACC_W  = OPW + 4;

  localparam int CORDIC_STEPS = 28;
  localparam int CSTEP_W      = 5;
  localparam int CXW          = 34;
  localparam int CZW          = 32;

  localparam int MC_STEPS = 48;
  localparam int MC_W     = $clog2(MC_STEPS);
  localparam int SEQ_W    = $clog2((MC_STEPS > CORDIC_STEPS) ? MC_STEPS : CORDIC_STEPS);

  localparam logic signed [TW-1:0]  ONE_Q30   = 32'sh4000_0000;
  localparam logic signed [CXW-1:0] CORDIC_X0 = CXW'(32'sd652032874);

  function automatic logic signed [CZW-1:0] atan_lut(input logic [CSTEP_W-1:0] i);
    logic signed [CZW-1:0] r;
    case (i)
      5'd0:    r = 32'sh20000000;
      5'd1:    r = 32'sh12E4051E;
      5'd2:    r = 32'sh09FB385B;
      5'd3:    r = 32'sh051111D4;
      5'd4:    r = 32'sh028B0D43;
      5'd5:    r = 32'sh0145D7E1;
      5'd6:    r = 32'sh00A2F61E;
      5'd7:    r = 32'sh00517C55;
      5'd8:    r = 32'sh0028BE53;
      5'd9:    r = 32'sh00145F2F;
      5'd10:   r = 32'sh000A2F98;
      5'd11:   r = 32'sh000517CC;
      5'd12:   r = 32'sh00028BE6;
      5'd13:   r = 32'sh000145F3;
      5'd14:   r = 32'sh0000A2FA;
      5'd15:   r = 32'sh0000517D;
      5'd16:   r = 32'sh000028BE;
      5'd17:   r = 32'sh0000145F;
      5'd18:   r = 32'sh00000A30;
      5'd19:   r = 32'sh00000518;
      5'd20:   r = 32'sh0000028C;
      5'd21:   r = 32'sh00000146;
      5'd22:   r = 32'sh000000A3;
      5'd23:   r = 32'sh00000051;
      5'd24:   r = 32'sh00000029;
      5'd25:   r = 32'sh00000014;
      5'd26:   r = 32'sh0000000A;
      5'd27:   r = 32'sh00000005;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef enum logic [3:0] {
    SRC_LX, SRC_LY, SRC_LEN, SRC_OFS, SRC_CT, SRC_ST, SRC_CA, SRC_SA,
    SRC_TI, SRC_LNK, SRC_ROT
  } src_e;

  typedef enum logic [1:0] {DST_T, DST_L, DST_TI, DST_NR} dst_e;

  typedef struct packed {
    src_e       a_sel;
    logic [3:0] a_idx;
    src_e       b_sel;
    logic [3:0] b_idx;
    logic       first;
    logic       last;
    logic       neg;
    dst_e       dst;
    logic [3:0] d_idx;
  } mc_t;

  typedef mc_t [MC_STEPS-1:0] mc_tab_t;

  function automatic mc_t mc_op(input src_e as, input int ai, input src_e bs, input int bi,
                                input logic f, input logic l, input logic n,
                                input dst_e d, input int di);
    mc_t m;
    m.a_sel = as;
    m.a_idx = 4'(ai);
    m.b_sel = bs;
    m.b_idx = 4'(bi);
    m.first = f;
    m.last  = l;
    m.neg   = n;
    m.dst   = d;
    m.d_idx = 4'(di);
    return m;
  endfunction

  function automatic mc_tab_t build_mc();
    mc_tab_t t;
    int n;
    t = '0;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      t[n] = mc_op(SRC_LX, 0, SRC_ROT, 3*i,   1'b1, 1'b0, 1'b0, DST_T, i); n++;
      t[n] = mc_op(SRC_LY, 0, SRC_ROT, 3*i+1, 1'b0, 1'b1, 1'b0, DST_T, i); n++;
    end
    t[n] = mc_op(SRC_ST, 0, SRC_CA, 0, 1'b1, 1'b1, 1'b1, DST_L, 1); n++;
    t[n] = mc_op(SRC_ST, 0, SRC_SA, 0, 1'b1, 1'b1, 1'b0, DST_L, 2); n++;
    t[n] = mc_op(SRC_CT, 0, SRC_CA, 0, 1'b1, 1'b1, 1'b0, DST_L, 4); n++;
    t[n] = mc_op(SRC_CT, 0, SRC_SA, 0, 1'b1, 1'b1, 1'b1, DST_L, 5); n++;
    t[n] = mc_op(SRC_LEN, 0, SRC_CT, 0, 1'b1, 1'b1, 1'b0, DST_TI, 0); n++;
    t[n] = mc_op(SRC_LEN, 0, SRC_ST, 0, 1'b1, 1'b1, 1'b0, DST_TI, 1); n++;
    for (int i = 0; i < 3; i++) begin
      t[n] = mc_op(SRC_TI,  0, SRC_ROT, 3*i,   1'b1, 1'b0, 1'b0, DST_T, i); n++;
      t[n] = mc_op(SRC_TI,  1, SRC_ROT, 3*i+1, 1'b0, 1'b0, 1'b0, DST_T, i); n++;
      t[n] = mc_op(SRC_OFS, 0, SRC_ROT, 3*i+2, 1'b0, 1'b1, 1'b0, DST_T, i); n++;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          t[n] = mc_op(SRC_LNK, 3*k+j, SRC_ROT, 3*i+k, k == 0, k == 2, 1'b0,
                       DST_NR, 3*i+j);
          n++;
        end
      end
    end
    return t;
  endfunction

  localparam mc_tab_t MC_TAB = build_mc();

  typedef enum logic [2:0] {ST_IDLE, ST_CORDIC, ST_MAC, ST_FLUSH, ST_COMMIT} state_e;

  typedef struct packed {
    logic               load;
    logic               cordic_step;
    logic [CSTEP_W-1:0] cstep;
    logic               mc_issue;
    logic [MC_W-1:0]    mc_idx;
    logic               commit;
  } ctl_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/dhfk_cordic.sv -----
module dhfk_cordic (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic                                step_i,
  input  logic [dhfk_pkg::CSTEP_W-1:0]        idx_i,
  input  logic [dhfk_pkg::ANGLE_WIDTH-1:0]    angle_i,
  output logic signed [dhfk_pkg::TW-1:0]      cos_o,
  output logic signed [dhfk_pkg::TW-1:0]      sin_o
);

  localparam int XW = dhfk_pkg::CXW;
  localparam logic signed [XW-1:0] HI = XW'(dhfk_pkg::ONE_Q30);
  localparam logic signed [XW-1:0] LO = -HI;

  logic signed [XW-1:0]            x_q, y_q;
  logic signed [dhfk_pkg::CZW-1:0] z_q;
  logic [1:0]                      q_q;
  logic [31:0]                     a32;
  logic signed [XW-1:0]            cx, sy, xs, ys;

  assign a32 = {angle_i, {(32 - dhfk_pkg::ANGLE_WIDTH){1'b0}}};
  assign xs  = x_q >>> idx_i;
  assign ys  = y_q >>> idx_i;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= dhfk_pkg::CORDIC_X0;
      y_q <= '0;
      z_q <= {{2{a32[29]}}, a32[29:0]};
      q_q <= a32[31:30] + {1'b0, a32[29]};
    end else if (step_i) begin
      if (!z_q[dhfk_pkg::CZW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - dhfk_pkg::atan_lut(idx_i);
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + dhfk_pkg::atan_lut(idx_i);
      end
    end
  end

  always_comb begin
    case (q_q)
      2'd0:    begin cx = x_q;  sy = y_q;  end
      2'd1:    begin cx = -y_q; sy = x_q;  end
      2'd2:    begin cx = -x_q; sy = -y_q; end
      default: begin cx = y_q;  sy = -x_q; end
    endcase
    cos_o = (cx > HI) ? HI[31:0] : ((cx < LO) ? LO[31:0] : cx[31:0]);
    sin_o = (sy > HI) ? HI[31:0] : ((sy < LO) ? LO[31:0] : sy[31:0]);
  end

endmodule

// ----- rtl/dhfk_ctrl.sv -----
module dhfk_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dhfk_pkg::sts_t       sts_i,
  output dhfk_pkg::ctl_t       ctl_o
);

  dhfk_pkg::state_e                state_q, state_d;
  logic [dhfk_pkg::SEQ_W-1:0]      cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dhfk_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      dhfk_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) state_d = dhfk_pkg::ST_CORDIC;
      end
      dhfk_pkg::ST_CORDIC: begin
        if (cnt_q == dhfk_pkg::SEQ_W'(dhfk_pkg::CORDIC_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = dhfk_pkg::ST_MAC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      dhfk_pkg::ST_MAC: begin
        if (cnt_q == dhfk_pkg::SEQ_W'(dhfk_pkg::MC_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = dhfk_pkg::ST_FLUSH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      dhfk_pkg::ST_FLUSH: state_d = dhfk_pkg::ST_COMMIT;
      dhfk_pkg::ST_COMMIT: begin
        if (sts_i.out_free) state_d = dhfk_pkg::ST_IDLE;
      end
      default: state_d = dhfk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o        = 1'b1;
    ctl_o             = '0;
    ctl_o.cstep       = cnt_q[dhfk_pkg::CSTEP_W-1:0];
    ctl_o.mc_idx      = cnt_q[dhfk_pkg::MC_W-1:0];
    case (state_q)
      dhfk_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        ctl_o.load = in_valid_i;
      end
      dhfk_pkg::ST_CORDIC: ctl_o.cordic_step = 1'b1;
      dhfk_pkg::ST_MAC:    ctl_o.mc_issue    = 1'b1;
      dhfk_pkg::ST_COMMIT: ctl_o.commit      = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/dhfk_datapath.sv -----
module dhfk_datapath (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  dhfk_pkg::ctl_t                           ctl_i,
  output dhfk_pkg::sts_t                           sts_o,
  input  logic signed [dhfk_pkg::ANGLE_WIDTH-1:0]  joint_angle_i,
  input  logic signed [dhfk_pkg::ANGLE_WIDTH-1:0]  angle_offset_i,
  input  logic signed [dhfk_pkg::ANGLE_WIDTH-1:0]  link_twist_i,
  input  logic signed [dhfk_pkg::LENGTH_WIDTH-1:0] link_length_i,
  input  logic signed [dhfk_pkg::LENGTH_WIDTH-1:0] link_offset_i,
  input  logic signed [dhfk_pkg::LENGTH_WIDTH-1:0] mount_x_i,
  input  logic signed [dhfk_pkg::LENGTH_WIDTH-1:0] mount_y_i,
  input  logic                                     roll_joint_i,
  input  logic                                     chain_end_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [31:0]                       origin_x_o,
  output logic signed [31:0]                       origin_y_o,
  output logic signed [31:0]                       origin_z_o,
  output logic signed [31:0]                       xaxis_x_o,
  output logic signed [31:0]                       xaxis_y_o,
  output logic signed [31:0]                       xaxis_z_o,
  output logic signed [31:0]                       zaxis_x_o,
  output logic signed [31:0]                       zaxis_y_o,
  output logic signed [31:0]                       zaxis_z_o,
  output logic [dhfk_pkg::CNT_W-1:0]               link_number_o,
  output logic                                     chain_done_o
);

  localparam int OPW   = dhfk_pkg::OPW;
  localparam int PW    = dhfk_pkg::PW;
  localparam int ACC_W = dhfk_pkg::ACC_W;
  localparam int TW    = dhfk_pkg::TW;
  localparam int LW    = dhfk_pkg::LENGTH_WIDTH;
  localparam int CW    = dhfk_pkg::CNT_W;

  localparam logic signed [PW-1:0]    RND_HALF = PW'(64'sh2000_0000);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Q_HI     = ACC_W'(dhfk_pkg::ONE_Q30);
  localparam logic signed [ACC_W-1:0] Q_LO     = -Q_HI;

  logic signed [LW-1:0]  len_q, ofs_q, mx_q, my_q;
  logic                  roll_q, last_q;
  logic signed [TW-1:0]  rot_q [9];
  logic signed [TW-1:0]  nr_q  [9];
  logic signed [TW-1:0]  t_q   [3];
  logic signed [TW-1:0]  l1_q, l2_q, l4_q, l5_q;
  logic signed [OPW-1:0] ti_q  [2];
  logic [CW-1:0]         cnt_q;
  logic                  out_valid_q;

  logic signed [PW-1:0]    prod_q;
  dhfk_pkg::mc_t           mcq_q;
  logic                    pv_q;
  logic signed [ACC_W-1:0] acc_q;

  logic [dhfk_pkg::ANGLE_WIDTH-1:0] theta;
  logic signed [TW-1:0]    ca_c, sa_c, cb_c, sb_c, ct, st, ca, sa, lnk;
  logic signed [OPW-1:0]   a_op, b_op;
  dhfk_pkg::mc_t           mc;
  logic signed [PW-1:0]    rnd;
  logic signed [ACC_W-1:0] term, base, sum, sat_v, clq_v;
  logic [CW-1:0]           cnt_nx;
  logic                    out_free;

  assign theta = joint_angle_i + angle_offset_i;

  dhfk_cordic u_cordic_a (
    .clk_i   (clk_i),
    .load_i  (ctl_i.load),
    .step_i  (ctl_i.cordic_step),
    .idx_i   (ctl_i.cstep),
    .angle_i (theta),
    .cos_o   (ca_c),
    .sin_o   (sa_c)
  );

  dhfk_cordic u_cordic_b (
    .clk_i   (clk_i),
    .load_i  (ctl_i.load),
    .step_i  (ctl_i.cordic_step),
    .idx_i   (ctl_i.cstep),
    .angle_i (link_twist_i),
    .cos_o   (cb_c),
    .sin_o   (sb_c)
  );

  always_comb begin
    ct = roll_q ? dhfk_pkg::ONE_Q30 : ca_c;
    st = roll_q ? '0 : sa_c;
    ca = roll_q ? ca_c : cb_c;
    sa = roll_q ? sa_c : sb_c;
  end

  assign mc = dhfk_pkg::MC_TAB[ctl_i.mc_idx];

  always_comb begin
    case (mc.a_idx)
      4'd0:    lnk = ct;
      4'd1:    lnk = l1_q;
      4'd2:    lnk = l2_q;
      4'd3:    lnk = st;
      4'd4:    lnk = l4_q;
      4'd5:    lnk = l5_q;
      4'd7:    lnk = sa;
      4'd8:    lnk = ca;
      default: lnk = '0;
    endcase
    case (mc.a_sel)
      dhfk_pkg::SRC_LX:  a_op = OPW'(mx_q);
      dhfk_pkg::SRC_LY:  a_op = OPW'(my_q);
      dhfk_pkg::SRC_LEN: a_op = OPW'(len_q);
      dhfk_pkg::SRC_OFS: a_op = OPW'(ofs_q);
      dhfk_pkg::SRC_CT:  a_op = OPW'(ct);
      dhfk_pkg::SRC_ST:  a_op = OPW'(st);
      dhfk_pkg::SRC_TI:  a_op = ti_q[mc.a_idx[0]];
      dhfk_pkg::SRC_LNK: a_op = OPW'(lnk);
      default:           a_op = '0;
    endcase
    case (mc.b_sel)
      dhfk_pkg::SRC_CT:  b_op = OPW'(ct);
      dhfk_pkg::SRC_ST:  b_op = OPW'(st);
      dhfk_pkg::SRC_CA:  b_op = OPW'(ca);
      dhfk_pkg::SRC_SA:  b_op = OPW'(sa);
      dhfk_pkg::SRC_ROT: b_op = OPW'(rot_q[mc.b_idx]);
      default:           b_op = '0;
    endcase
  end

  always_comb begin
    rnd   = (prod_q + RND_HALF) >>> 30;
    term  = mcq_q.neg ? -$signed(rnd[ACC_W-1:0]) : $signed(rnd[ACC_W-1:0]);
    if (!mcq_q.first)                    base = acc_q;
    else if (mcq_q.dst == dhfk_pkg::DST_T) base = ACC_W'(t_q[mcq_q.d_idx[1:0]]);
    else                                 base = '0;
    sum   = base + term;
    sat_v = (sum > SAT_HI) ? SAT_HI : ((sum < SAT_LO) ? SAT_LO : sum);
    clq_v = (sum > Q_HI) ? Q_HI : ((sum < Q_LO) ? Q_LO : sum);
    cnt_nx = (cnt_q < CW'(dhfk_pkg::MAX_LINKS)) ? cnt_q + 1'b1 : cnt_q;
  end

  assign out_free       = !out_valid_q || !out_stall_i;
  assign sts_o.out_free = out_free;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      len_q  <= link_length_i;
      ofs_q  <= link_offset_i;
      mx_q   <= mount_x_i;
      my_q   <= mount_y_i;
      roll_q <= roll_joint_i;
      last_q <= chain_end_i;
    end
    prod_q <= a_op * b_op;
    mcq_q  <= mc;
    if (pv_q) begin
      acc_q <= sum;
      if (mcq_q.last) begin
        case (mcq_q.dst)
          dhfk_pkg::DST_L: begin
            case (mcq_q.d_idx)
              4'd1:    l1_q <= TW'(sum);
              4'd2:    l2_q <= TW'(sum);
              4'd4:    l4_q <= TW'(sum);
              4'd5:    l5_q <= TW'(sum);
              default: ;
            endcase
          end
          dhfk_pkg::DST_TI: ti_q[mcq_q.d_idx[0]] <= OPW'(sum);
          dhfk_pkg::DST_NR: nr_q[mcq_q.d_idx]    <= TW'(clq_v);
          default: ;
        endcase
      end
    end
    if (ctl_i.commit) begin
      origin_x_o    <= t_q[0];
      origin_y_o    <= t_q[1];
      origin_z_o    <= t_q[2];
      xaxis_x_o     <= nr_q[0];
      xaxis_y_o     <= nr_q[3];
      xaxis_z_o     <= nr_q[6];
      zaxis_x_o     <= nr_q[2];
      zaxis_y_o     <= nr_q[5];
      zaxis_z_o     <= nr_q[8];
      link_number_o <= cnt_nx;
      chain_done_o  <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      for (int i = 0; i < 9; i++) begin
        rot_q[i] <= (i % 4 == 0) ? dhfk_pkg::ONE_Q30 : '0;
      end
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= '0;
      end
    end else begin
      pv_q <= ctl_i.mc_issue;
      if (ctl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pv_q && mcq_q.last && mcq_q.dst == dhfk_pkg::DST_T) begin
        t_q[mcq_q.d_idx[1:0]] <= TW'(sat_v);
      end
      if (ctl_i.commit) begin
        if (last_q) begin
          cnt_q <= '0;
          for (int i = 0; i < 9; i++) begin
            rot_q[i] <= (i % 4 == 0) ? dhfk_pkg::ONE_Q30 : '0;
          end
          for (int i = 0; i < 3; i++) begin
            t_q[i] <= '0;
          end
        end else begin
          cnt_q <= cnt_nx;
          for (int i = 0; i < 9; i++) begin
            rot_q[i] <= nr_q[i];
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/dh_forward_kinematics_chain_top.sv -----
// Forward kinematics of a serial arm, one link per input item.
// Input channel: in_valid_i / in_stall_o with the link fields; an item is
// taken at a clock edge with valid high and stall low. Output channel:
// out_valid_o / out_stall_i with the frame origin, x and z axes, link number
// and chain_done for the link just applied.
// Each item goes from acceptance to its result in order: the accepting edge
// loads the item, then 28 CORDIC steps (twist and joint angle run side by
// side), 48 steps of the single shared 33x33 multiply-accumulate unit, a
// pipeline flush and a commit. No new item is taken before the last one has
// committed; the next can be taken in the cycle after commit. The input stalls
// from acceptance until commit; the last result may still wait downstream.
// The result sits in an output register until taken; a stalled result holds,
// and the commit of the next item waits until that register is free.
// Reset sets the transform to identity, the origin to zero and the link
// count to zero; the same happens after the item marked chain_end.
module dh_forward_kinematics_chain_top (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [dhfk_pkg::ANGLE_WIDTH-1:0]  joint_angle_i,
  input  logic signed [dhfk_pkg::ANGLE_WIDTH-1:0]  angle_offset_i,
  input  logic signed [dhfk_pkg::ANGLE_WIDTH-1:0]  link_twist_i,
  input  logic signed [dhfk_pkg::LENGTH_WIDTH-1:0] link_length_i,
  input  logic signed [dhfk_pkg::LENGTH_WIDTH-1:0] link_offset_i,
  input  logic signed [dhfk_pkg::LENGTH_WIDTH-1:0] mount_x_i,
  input  logic signed [dhfk_pkg::LENGTH_WIDTH-1:0] mount_y_i,
  input  logic                                     roll_joint_i,
  input  logic                                     chain_end_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [31:0]                       origin_x_o,
  output logic signed [31:0]                       origin_y_o,
  output logic signed [31:0]                       origin_z_o,
  output logic signed [31:0]                       xaxis_x_o,
  output logic signed [31:0]                       xaxis_y_o,
  output logic signed [31:0]                       xaxis_z_o,
  output logic signed [31:0]                       zaxis_x_o,
  output logic signed [31:0]                       zaxis_y_o,
  output logic signed [31:0]                       zaxis_z_o,
  output logic [dhfk_pkg::CNT_W-1:0]               link_number_o,
  output logic                                     chain_done_o
);

  dhfk_pkg::ctl_t ctl;
  dhfk_pkg::sts_t sts;

  dhfk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  dhfk_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .joint_angle_i  (joint_angle_i),
    .angle_offset_i (angle_offset_i),
    .link_twist_i   (link_twist_i),
    .link_length_i  (link_length_i),
    .link_offset_i  (link_offset_i),
    .mount_x_i      (mount_x_i),
    .mount_y_i      (mount_y_i),
    .roll_joint_i   (roll_joint_i),
    .chain_end_i    (chain_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .origin_x_o     (origin_x_o),
    .origin_y_o     (origin_y_o),
    .origin_z_o     (origin_z_o),
    .xaxis_x_o      (xaxis_x_o),
    .xaxis_y_o      (xaxis_y_o),
    .xaxis_z_o      (xaxis_z_o),
    .zaxis_x_o      (zaxis_x_o),
    .zaxis_y_o      (zaxis_y_o),
    .zaxis_z_o      (zaxis_z_o),
    .link_number_o  (link_number_o),
    .chain_done_o   (chain_done_o)
  );

endmodule

// ----- rtl/dhfk_checker.sv -----
module dhfk_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [dhfk_pkg::CNT_W-1:0]  link_number_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  a_stalled_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(link_number_o))
    else $error("stalled result changed");

  a_link_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> link_number_o != '0 &&
                    link_number_o <= dhfk_pkg::CNT_W'(dhfk_pkg::MAX_LINKS))
    else $error("link number out of range");

endmodule

bind dh_forward_kinematics_chain_top dhfk_checker u_dhfk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .link_number_o (link_number_o)
);

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW = dhfk_pkg::ANGLE_WIDTH;
  localparam int LW = dhfk_pkg::LENGTH_WIDTH;
  localparam int N_RANDOM = 1950;
  localparam int LATENCY = 79;
  localparam longint Q30 = 64'sd1 << 30;

  typedef struct {
    logic [AW-1:0] joint_angle;
    logic [AW-1:0] angle_offset;
    logic [AW-1:0] link_twist;
    logic [LW-1:0] link_length;
    logic [LW-1:0] link_offset;
    logic [LW-1:0] mount_x;
    logic [LW-1:0] mount_y;
    logic          roll_joint;
    logic          chain_end;
  } link_t;

  typedef struct {
    logic [31:0] origin[3];
    logic [31:0] xaxis[3];
    logic [31:0] zaxis[3];
    logic [3:0]  link_number;
    logic        chain_done;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [AW-1:0] joint_angle_i = '0, angle_offset_i = '0, link_twist_i = '0;
  logic signed [LW-1:0] link_length_i = '0, link_offset_i = '0;
  logic signed [LW-1:0] mount_x_i = '0, mount_y_i = '0;
  logic roll_joint_i = 1'b0, chain_end_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] origin_x_o, origin_y_o, origin_z_o;
  logic signed [31:0] xaxis_x_o, xaxis_y_o, xaxis_z_o;
  logic signed [31:0] zaxis_x_o, zaxis_y_o, zaxis_z_o;
  logic [dhfk_pkg::CNT_W-1:0] link_number_o;
  logic chain_done_o;

  dh_forward_kinematics_chain_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  longint rot_m[9];
  longint trans_m[3];
  int     links_seen;
  frame_t expected_frames[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     hold_req = 0;
  int     hold_off = 0;
  bit     hold_taken = 1'b0;
  bit     stim_done = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat32(longint v);
    return clampv(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    longint ah, al;
    ah = asr(a, 30);
    al = a - ah * Q30;
    return ah * b + asr(al * b + (64'sd1 << 29), 30);
  endfunction

  function automatic void cordic_sincos(logic [AW-1:0] ang, output longint c,
                                        output longint s);
    logic [31:0] a32;
    int q;
    longint z, x, y, t, cx, sy;
    a32 = {ang, {(32-AW){1'b0}}};
    q = a32[31:30];
    z = longint'(a32[29:0]);
    x = 652032874;
    y = 0;
    if (z >= (64'sd1 << 29)) begin
      z -= Q30;
      q = (q + 1) & 3;
    end
    for (int i = 0; i < dhfk_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        t = x - asr(y, i); y = y + asr(x, i);
        z -= longint'(dhfk_pkg::atan_lut(5'(i)));
      end else begin
        t = x + asr(y, i); y = y - asr(x, i);
        z += longint'(dhfk_pkg::atan_lut(5'(i)));
      end
      x = t;
    end
    case (q)
      0: begin cx = x; sy = y; end
      1: begin cx = -y; sy = x; end
      2: begin cx = -x; sy = -y; end
      default: begin cx = y; sy = -x; end
    endcase
    c = clampv(cx, -Q30, Q30);
    s = clampv(sy, -Q30, Q30);
  endfunction

  function automatic void reset_chain();
    for (int i = 0; i < 9; i++) rot_m[i] = (i % 4 == 0) ? Q30 : 0;
    for (int i = 0; i < 3; i++) trans_m[i] = 0;
    links_seen = 0;
  endfunction

  function automatic frame_t apply_link(link_t l);
    logic [AW-1:0] theta;
    longint a, d, lx, ly, ct, st, ca, sa, acc;
    longint li[9], ti[3], nr[9];
    frame_t f;
    theta = l.joint_angle + l.angle_offset;
    a = longint'(signed'(l.link_length));
    d = longint'(signed'(l.link_offset));
    lx = longint'(signed'(l.mount_x));
    ly = longint'(signed'(l.mount_y));
    for (int i = 0; i < 3; i++)
      trans_m[i] = sat32(trans_m[i] + mul_q30(lx, rot_m[i*3]) + mul_q30(ly, rot_m[i*3+1]));
    if (l.roll_joint) begin
      ct = Q30; st = 0;
      cordic_sincos(theta, ca, sa);
    end else begin
      cordic_sincos(theta, ct, st);
      cordic_sincos(l.link_twist, ca, sa);
    end
    li[0] = ct; li[1] = -mul_q30(st, ca); li[2] = mul_q30(st, sa);
    li[3] = st; li[4] = mul_q30(ct, ca);  li[5] = -mul_q30(ct, sa);
    li[6] = 0;  li[7] = sa;               li[8] = ca;
    ti[0] = mul_q30(a, ct); ti[1] = mul_q30(a, st); ti[2] = d;
    for (int i = 0; i < 3; i++) begin
      acc = trans_m[i];
      for (int k = 0; k < 3; k++) acc += mul_q30(ti[k], rot_m[i*3+k]);
      trans_m[i] = sat32(acc);
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += mul_q30(rot_m[i*3+k], li[k*3+j]);
        nr[i*3+j] = clampv(acc, -Q30, Q30);
      end
    for (int i = 0; i < 9; i++) rot_m[i] = nr[i];
    if (links_seen < dhfk_pkg::MAX_LINKS) links_seen++;
    for (int i = 0; i < 3; i++) begin
      f.origin[i] = 32'(trans_m[i]);
      f.xaxis[i] = 32'(rot_m[i*3]);
      f.zaxis[i] = 32'(rot_m[i*3+2]);
    end
    f.link_number = 4'(links_seen);
    f.chain_done = l.chain_end;
    if (l.chain_end) reset_chain();
    return f;
  endfunction

  function automatic link_t mk(int ja, int ao, int tw, int len, int ofs, int mx, int my,
                               bit roll, bit last);
    link_t l;
    l.joint_angle = AW'(ja); l.angle_offset = AW'(ao); l.link_twist = AW'(tw);
    l.link_length = LW'(len); l.link_offset = LW'(ofs);
    l.mount_x = LW'(mx); l.mount_y = LW'(my);
    l.roll_joint = roll; l.chain_end = last;
    return l;
  endfunction

  function automatic logic [LW-1:0] rand_len();
    case ($urandom_range(0, 5))
      0: return LW'($urandom_range(0, 3)) ? {1'b0, {(LW-1){1'b1}}} : {1'b1, {(LW-1){1'b0}}};
      1, 2: return LW'($urandom);
      default: return LW'(signed'(17'($urandom)));
    endcase
  endfunction

  function automatic link_t rand_link();
    link_t l;
    l.joint_angle = AW'($urandom); l.angle_offset = AW'($urandom);
    l.link_twist = ($urandom_range(0, 3) == 0) ? AW'($urandom_range(0, 3) << (AW - 2))
                                                : AW'($urandom);
    l.link_length = rand_len(); l.link_offset = rand_len();
    l.mount_x = ($urandom_range(0, 2) == 0) ? '0 : rand_len();
    l.mount_y = ($urandom_range(0, 2) == 0) ? '0 : rand_len();
    l.roll_joint = ($urandom_range(0, 3) == 0);
    l.chain_end = ($urandom_range(0, 5) == 0);
    return l;
  endfunction

  task automatic send_link(link_t l);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    joint_angle_i <= l.joint_angle; angle_offset_i <= l.angle_offset;
    link_twist_i <= l.link_twist; link_length_i <= l.link_length;
    link_offset_i <= l.link_offset; mount_x_i <= l.mount_x; mount_y_i <= l.mount_y;
    roll_joint_i <= l.roll_joint; chain_end_i <= l.chain_end;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_frames.push_back(apply_link(l));
  endtask

  task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    frame_t e;
    logic [31:0] act[9];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      act = '{origin_x_o, origin_y_o, origin_z_o, xaxis_x_o, xaxis_y_o, xaxis_z_o,
              zaxis_x_o, zaxis_y_o, zaxis_z_o};
      if (expected_frames.size() == 0) begin
        note_mismatch("unexpected item", 0, 0);
      end else begin
        e = expected_frames.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (act[i] !== e.origin[i])
            note_mismatch($sformatf("origin[%0d]", i), e.origin[i], act[i]);
          if (act[3+i] !== e.xaxis[i])
            note_mismatch($sformatf("xaxis[%0d]", i), e.xaxis[i], act[3+i]);
          if (act[6+i] !== e.zaxis[i])
            note_mismatch($sformatf("zaxis[%0d]", i), e.zaxis[i], act[6+i]);
        end
        if (link_number_o !== e.link_number)
          note_mismatch("link_number", 32'(e.link_number), 32'(link_number_o));
        if (chain_done_o !== e.chain_done)
          note_mismatch("chain_done", 32'(e.chain_done), 32'(chain_done_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_req > 0 && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_off <= hold_req - 1;
      out_stall_i <= 1'b1;
    end else if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall_i <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    #100ms;
    $display("dh_forward_kinematics_chain_top verification failed");
    $finish;
  end

  initial begin
    link_t directed[$];
    int n;
    reset_chain();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero link from reset: origin zero, link one, chain done
    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1));
    directed.push_back(mk(32767, 1, 0, 65536, 0, 0, 0, 0, 0));
    directed.push_back(mk(-32768, -32768, 16384, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0));
    directed.push_back(mk(16384, 0, -32768, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h80000000, 0, 0));
    directed.push_back(mk(8192, 8192, 0, 65536, 65536, 65536, -65536, 1, 0));
    directed.push_back(mk(-1, 0, 32767, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 1, 0));
    for (int i = 0; i < 6; i++)
      directed.push_back(mk(4096 * i, -1000, 8192, 100000, -5000, 0, 0, i[0], 0));
    directed.push_back(mk(12345, 0, -8192, 65536, 65536, 32, -32, 0, 1));
    directed.push_back(mk(0, 0, 0, 65536, 0, 0, 0, 1, 1));

    foreach (directed[i]) begin
      send_link(directed[i]);
      if (i == 0) begin
        for (int k = 0; k < 3; k++)
          if (expected_frames[expected_frames.size()-1].origin[k] !== 32'd0)
            note_mismatch("zero origin", 0, expected_frames[expected_frames.size()-1].origin[k]);
        if (expected_frames[expected_frames.size()-1].link_number !== 4'd1)
          note_mismatch("first link number", 1,
                        32'(expected_frames[expected_frames.size()-1].link_number));
        if (expected_frames[expected_frames.size()-1].chain_done !== 1'b1)
          note_mismatch("first chain done", 1, 0);
      end
    end

    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 64; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 64; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      if (ph == 2) hold_req = 600;
      for (int i = 0; i < N_RANDOM / 4; i++) send_link(rand_link());
      n += N_RANDOM / 4;
    end
    in_valid_i <= 1'b0;
    stall_pct = 0;
    send_idle_pct = 0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (LATENCY * 2) @(posedge clk_i);
    if (errors == 0) begin
      $display("dh_forward_kinematics_chain_top verification clean");
    end else begin
      $display("dh_forward_kinematics_chain_top verification failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/dhfk_pkg.sv
rtl/dhfk_cordic.sv
rtl/dhfk_ctrl.sv
rtl/dhfk_datapath.sv
rtl/dh_forward_kinematics_chain_top.sv
rtl/dhfk_checker.sv
test/tb.sv
